// File: rtl/core/tun_pkg.sv
package tun_pkg;

    // Fixed field widths
    localparam int COORD_WIDTH          = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int CFG_WIDTH            = 32;
    localparam int OUT_WIDTH            = 16;

    // Datapath widths
    localparam int EDGE_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = (PROD_W > CFG_WIDTH) ? PROD_W : CFG_WIDTH;
    localparam int NORM_STEPS = $clog2(MAG_W);
    localparam int SCALE_W    = 30;
    localparam int SUM_W      = 2 * SCALE_W + 2;
    localparam int ROOT_W     = SUM_W / 2;

    // edge, product, cross, magnitude, shifter stages, square, sum
    localparam int FRONT_LAT  = 6 + NORM_STEPS;

    localparam logic [CFG_WIDTH-1:0] MIN_LENGTH_RST = 32'd17;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0]   norm_t;
    typedef logic [SCALE_W-1:0]            scale_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
        logic   swap_winding;
    } tun_in_t;

    typedef struct packed {
        norm_t normal_x;
        norm_t normal_y;
        norm_t normal_z;
        logic  degenerate;
    } tun_out_t;

    // Front end to root/divide back end
    typedef struct packed {
        logic               valid;
        logic               degen;
        logic [2:0]         neg;
        scale_t [2:0]       s;
        logic [SUM_W-1:0]   sum;
    } tun_mid_t;

endpackage

// File: rtl/core/tun_front.sv
module tun_front
    import tun_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tun_in_t              item,
    input  logic [CFG_WIDTH-1:0] min_length,
    output tun_mid_t             mid
);

    localparam int SQ_W  = 2 * CFG_WIDTH;
    localparam int SS_W  = 2 * SCALE_W;
    localparam int LAST  = NORM_STEPS - 1;

    // stage 1: edges
    coord_t bx, by, bz, cx, cy, cz;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic v1_reg;

    // stage 2: products
    logic signed [PROD_W-1:0] p_reg [6];
    logic v2_reg;

    // stage 3: cross components
    logic signed [CROSS_W-1:0] cr_reg [3];
    logic v3_reg;

    // stage 4: sign and magnitude
    logic signed [CROSS_W-1:0] abs_v [3];
    logic [2:0][MAG_W-1:0] mag_reg;
    logic [2:0] neg4_reg;
    logic v4_reg;

    // degenerate test, runs beside the shifter
    logic big_reg;
    logic [SQ_W-1:0] sq_reg [3];
    logic [SQ_W-1:0] msq_reg;
    logic [SQ_W+1:0] dsum;
    logic dg_reg [1:LAST];

    // normalizing shifter
    logic [2:0][MAG_W-1:0] sh_reg [NORM_STEPS];
    logic [2:0] nsh_reg [NORM_STEPS];
    logic vsh_reg [NORM_STEPS];

    // squares and sum
    scale_t [2:0] s_last;
    scale_t [2:0] ssq_reg;
    logic [SS_W-1:0] sqs_reg [3];
    logic [2:0] nsq_reg;
    logic dsq_reg;
    logic vsq_reg;

    scale_t [2:0] ms_reg;
    logic [SUM_W-1:0] msum_reg;
    logic [2:0] mneg_reg;
    logic mdg_reg;
    logic mv_reg;

    always_comb
    begin
        if (item.swap_winding)
        begin
            bx = item.c_x; by = item.c_y; bz = item.c_z;
            cx = item.b_x; cy = item.b_y; cz = item.b_z;
        end
        else
        begin
            bx = item.b_x; by = item.b_y; bz = item.b_z;
            cx = item.c_x; cy = item.c_y; cz = item.c_z;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_v[i] = cr_reg[i][CROSS_W-1] ? -cr_reg[i] : cr_reg[i];
        end
        dsum = (SQ_W+2)'(sq_reg[0]) + (SQ_W+2)'(sq_reg[1]) + (SQ_W+2)'(sq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            s_last[i] = sh_reg[LAST][i][MAG_W-1 -: SCALE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg[0] <= EDGE_W'(bx) - EDGE_W'(item.a_x);
        e1_reg[1] <= EDGE_W'(by) - EDGE_W'(item.a_y);
        e1_reg[2] <= EDGE_W'(bz) - EDGE_W'(item.a_z);
        e2_reg[0] <= EDGE_W'(cx) - EDGE_W'(item.a_x);
        e2_reg[1] <= EDGE_W'(cy) - EDGE_W'(item.a_y);
        e2_reg[2] <= EDGE_W'(cz) - EDGE_W'(item.a_z);

        p_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
        p_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
        p_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
        p_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
        p_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
        p_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);

        cr_reg[0] <= CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
        cr_reg[1] <= CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
        cr_reg[2] <= CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);

        for (int i = 0; i < 3; i++)
        begin
            neg4_reg[i] <= cr_reg[i][CROSS_W-1];
            mag_reg[i]  <= MAG_W'(abs_v[i][PROD_W-1:0]);
        end

        big_reg <= (mag_reg[0] > MAG_W'(min_length)) | (mag_reg[1] > MAG_W'(min_length))
                 | (mag_reg[2] > MAG_W'(min_length));
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= SQ_W'(mag_reg[i][CFG_WIDTH-1:0]) * SQ_W'(mag_reg[i][CFG_WIDTH-1:0]);
        end
        msq_reg <= SQ_W'(min_length) * SQ_W'(min_length);
        dg_reg[1] <= !big_reg && (dsum <= (SQ_W+2)'(msq_reg));
        for (int j = 2; j <= LAST; j++)
        begin
            dg_reg[j] <= dg_reg[j-1];
        end

        ssq_reg <= s_last;
        for (int i = 0; i < 3; i++)
        begin
            sqs_reg[i] <= SS_W'(s_last[i]) * SS_W'(s_last[i]);
        end
        nsq_reg <= nsh_reg[LAST];
        dsq_reg <= dg_reg[LAST];

        ms_reg   <= ssq_reg;
        msum_reg <= SUM_W'(sqs_reg[0]) + SUM_W'(sqs_reg[1]) + SUM_W'(sqs_reg[2]);
        mneg_reg <= nsq_reg;
        mdg_reg  <= dsq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vsq_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            vsq_reg <= vsh_reg[LAST];
            mv_reg  <= vsq_reg;
        end
    end

    // Left shift by halving amounts until the largest magnitude tops the word
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int AMT = 1 << (NORM_STEPS - 1 - j);
        logic [2:0][MAG_W-1:0] src;
        logic [2:0][MAG_W-1:0] dst;
        logic [2:0] src_neg;
        logic src_v;
        logic [MAG_W-1:0] any_bits;

        if (j == 0)
        begin : g_src0
            assign src     = mag_reg;
            assign src_neg = neg4_reg;
            assign src_v   = v4_reg;
        end
        else
        begin : g_srcn
            assign src     = sh_reg[j-1];
            assign src_neg = nsh_reg[j-1];
            assign src_v   = vsh_reg[j-1];
        end

        always_comb
        begin
            any_bits = src[0] | src[1] | src[2];
            if (any_bits[MAG_W-1 -: AMT] == '0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dst[i] = src[i] << AMT;
                end
            end
            else
            begin
                dst = src;
            end
        end

        always_ff @(posedge clk)
        begin
            sh_reg[j]  <= dst;
            nsh_reg[j] <= src_neg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vsh_reg[j] <= 1'b0;
            end
            else
            begin
                vsh_reg[j] <= src_v;
            end
        end
    end

    always_comb
    begin
        mid.valid = mv_reg;
        mid.degen = mdg_reg;
        mid.neg   = mneg_reg;
        mid.s     = ms_reg;
        mid.sum   = msum_reg;
    end

endmodule

// File: rtl/core/tun_back.sv
module tun_back
    import tun_pkg::*;
#(
    parameter int FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tun_mid_t                 mid,
    output logic                     out_valid,
    output logic [2:0][FRAC_BITS:0]  quot,
    output logic [2:0]               neg,
    output logic                     degen
);

    localparam int REM_W  = ROOT_W + 2;
    localparam int NUM_W  = SCALE_W + FRAC_BITS + 2;
    localparam int DSTEPS = FRAC_BITS + 1;
    localparam logic [SUM_W-1:0] SUM_FLOOR = SUM_W'(1) << (2 * SCALE_W - 2);
    localparam logic [FRAC_BITS:0] Q_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // square root pipeline, one root bit per stage
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    scale_t [2:0]      rs_reg   [ROOT_W];
    logic [2:0]        rneg_reg [ROOT_W];
    logic              rdg_reg  [ROOT_W];
    logic              rv_reg   [ROOT_W];

    // divider setup
    logic [2:0][NUM_W-1:0] num_reg;
    logic [ROOT_W-1:0]     len_reg;
    logic [2:0]            ineg_reg;
    logic                  idg_reg;
    logic                  iv_reg;

    // divider pipeline, one quotient bit per stage
    logic [2:0][NUM_W-1:0]     drem_reg [DSTEPS];
    logic [2:0][FRAC_BITS:0]   dq_reg   [DSTEPS];
    logic [ROOT_W-1:0]         dlen_reg [DSTEPS];
    logic [2:0]                dneg_reg [DSTEPS];
    logic                      ddg_reg  [DSTEPS];
    logic                      dv_reg   [DSTEPS];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [SUM_W-1:0]  src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        scale_t [2:0]      src_s;
        logic [2:0]        src_neg;
        logic              src_dg;
        logic              src_v;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  tst;
        logic [REM_W-1:0]  rem_n;
        logic [ROOT_W-1:0] root_n;

        if (k == 0)
        begin : g_src0
            assign src_rad  = mid.sum;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_s    = mid.s;
            assign src_neg  = mid.neg;
            assign src_dg   = mid.degen;
            assign src_v    = mid.valid;
        end
        else
        begin : g_srcn
            assign src_rad  = rad_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_root = root_reg[k-1];
            assign src_s    = rs_reg[k-1];
            assign src_neg  = rneg_reg[k-1];
            assign src_dg   = rdg_reg[k-1];
            assign src_v    = rv_reg[k-1];
        end

        always_comb
        begin
            trial = {src_rem, src_rad[SUM_W-1 -: 2]};
            tst   = (REM_W+2)'({src_root, 2'b01});
            if (trial >= tst)
            begin
                rem_n  = REM_W'(trial - tst);
                root_n = {src_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_n  = REM_W'(trial);
                root_n = {src_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= src_rad << 2;
            rem_reg[k]  <= rem_n;
            root_reg[k] <= root_n;
            rs_reg[k]   <= src_s;
            rneg_reg[k] <= src_neg;
            rdg_reg[k]  <= src_dg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[k] <= 1'b0;
            end
            else
            begin
                rv_reg[k] <= src_v;
            end
        end
    end

    // numerator carries the rounding half: s * 2^(F+1) + len over 2 * len
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= NUM_W'({rs_reg[ROOT_W-1][i], {(FRAC_BITS+1){1'b0}}})
                        + NUM_W'(root_reg[ROOT_W-1]);
        end
        len_reg  <= root_reg[ROOT_W-1];
        ineg_reg <= rneg_reg[ROOT_W-1];
        idg_reg  <= rdg_reg[ROOT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else
        begin
            iv_reg <= rv_reg[ROOT_W-1];
        end
    end

    for (genvar k = 0; k < DSTEPS; k++)
    begin : g_div
        localparam int SH = FRAC_BITS - k + 1;
        logic [2:0][NUM_W-1:0]   src_rem;
        logic [2:0][FRAC_BITS:0] src_q;
        logic [ROOT_W-1:0]       src_len;
        logic [2:0]              src_neg;
        logic                    src_dg;
        logic                    src_v;
        logic [NUM_W-1:0]        dd;
        logic [2:0][NUM_W-1:0]   rem_n;
        logic [2:0][FRAC_BITS:0] q_n;

        if (k == 0)
        begin : g_src0
            assign src_rem = num_reg;
            assign src_q   = '0;
            assign src_len = len_reg;
            assign src_neg = ineg_reg;
            assign src_dg  = idg_reg;
            assign src_v   = iv_reg;
        end
        else
        begin : g_srcn
            assign src_rem = drem_reg[k-1];
            assign src_q   = dq_reg[k-1];
            assign src_len = dlen_reg[k-1];
            assign src_neg = dneg_reg[k-1];
            assign src_dg  = ddg_reg[k-1];
            assign src_v   = dv_reg[k-1];
        end

        always_comb
        begin
            dd = NUM_W'(src_len) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (src_rem[i] >= dd)
                begin
                    rem_n[i] = src_rem[i] - dd;
                    q_n[i]   = {src_q[i][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_n[i] = src_rem[i];
                    q_n[i]   = {src_q[i][FRAC_BITS-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            drem_reg[k] <= rem_n;
            dq_reg[k]   <= q_n;
            dlen_reg[k] <= src_len;
            dneg_reg[k] <= src_neg;
            ddg_reg[k]  <= src_dg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else
            begin
                dv_reg[k] <= src_v;
            end
        end
    end

    assign out_valid = dv_reg[DSTEPS-1];
    assign quot      = dq_reg[DSTEPS-1];
    assign neg       = dneg_reg[DSTEPS-1];
    assign degen     = ddg_reg[DSTEPS-1];

    // A usable triangle reaches the root with its largest component normalized
    a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
        mid.valid && !mid.degen |-> mid.sum >= SUM_FLOOR)
        else $error("normalized sum of squares below floor");

    // Each component is at most one after the divide
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degen |-> quot[0] <= Q_ONE && quot[1] <= Q_ONE && quot[2] <= Q_ONE)
        else $error("normal component above one");

endmodule

// File: rtl/core/triangle_unit_normal.sv
//  channel   | signals                           | transaction
//  ----------+-----------------------------------+--------------------------------------
//  command   | start, busy, triangle             | start && !busy: one triangle taken
//  result    | done, result                      | done high one cycle: one normal out
//  config    | cfg_valid, cfg_ready, cfg_data    | cfg_valid && cfg_ready: min_length
//
//  Fully pipelined: one triangle per clock, through the front end, root stages, divider
//  setup, divide stages and output register. The root is taken one bit per stage
//  (31 stages) and each divide one quotient bit per stage (FRAC + 1 stages).
//  busy never rises and results are never held: the pipeline has no stall path.
//  Reset clears the valid bits along the pipe and loads min_length with 17.
module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tun_in_t              triangle,
    output logic                 done,
    output tun_out_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    localparam int QX_W    = NORMAL_FRAC_BITS + OUT_WIDTH + 1;
    localparam int LATENCY = FRONT_LAT + ROOT_W + NORMAL_FRAC_BITS + 3;
    localparam logic [OUT_WIDTH-1:0] Y_ONE = OUT_WIDTH'(1) << NORMAL_FRAC_BITS;

    logic [CFG_WIDTH-1:0] min_length_reg;
    logic                 accept;

    tun_mid_t mid;

    logic                           bk_valid;
    logic [2:0][NORMAL_FRAC_BITS:0] bk_quot;
    logic [2:0]                     bk_neg;
    logic                           bk_degen;

    logic [QX_W-1:0]      qe [3];
    logic [QX_W-1:0]      qs [3];
    logic [QX_W-1:0]      one_w;
    tun_out_t             result_next;
    tun_out_t             result_reg;
    logic                 done_reg;

    // No stall anywhere, so commands and config writes are always taken
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_length_reg <= cfg_data;
        end
    end

    // edges, cross product, degenerate test, normalizing shift, sum of squares
    tun_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .item       (triangle),
        .min_length (min_length_reg),
        .mid        (mid)
    );

    // root of the sum, then three rounded divides
    tun_back #(
        .FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .out_valid (bk_valid),
        .quot      (bk_quot),
        .neg       (bk_neg),
        .degen     (bk_degen)
    );

    // apply signs, truncate to the Q1.14 port, substitute the fallback normal
    always_comb
    begin
        one_w = QX_W'(1) << NORMAL_FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            qe[i] = QX_W'(bk_quot[i]);
            qs[i] = bk_neg[i] ? -qe[i] : qe[i];
        end
        if (bk_degen)
        begin
            result_next.normal_x   = '0;
            result_next.normal_y   = one_w[OUT_WIDTH-1:0];
            result_next.normal_z   = '0;
            result_next.degenerate = 1'b1;
        end
        else
        begin
            result_next.normal_x   = qs[0][OUT_WIDTH-1:0];
            result_next.normal_y   = qs[1][OUT_WIDTH-1:0];
            result_next.normal_z   = qs[2][OUT_WIDTH-1:0];
            result_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= bk_valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted triangle comes out after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing at pipeline latency");

    // Command and config channels never push back
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("stall raised on a pipeline without stall path");

    // A degenerate transaction carries the fallback normal
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |->
            result.normal_x == '0 && result.normal_y == Y_ONE && result.normal_z == '0)
        else $error("degenerate result without fallback normal");

endmodule

// File: dv/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps

module tb_triangle_unit_normal;
    import tun_pkg::*;

    // Pipeline depth of the unit under test.
    localparam int PIPE_DEPTH  = FRONT_LAT + ROOT_W + NORMAL_FRAC_BITS_DEF + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FRAC        = NORMAL_FRAC_BITS_DEF;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    tun_in_t              triangle;
    logic                 done;
    tun_out_t             result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data;

    // Predictor copy of the threshold register.
    logic [CFG_WIDTH-1:0] min_len_q;
    // Normals still owed by the pipeline, oldest first.
    tun_out_t             pending_normals[$];
    int                   err_count;
    int                   cycle_count;
    int                   sent_count;
    int                   normal_count;
    int                   degen_count;
    bit                   steady_stream;   // no idle gaps between transactions

    triangle_unit_normal uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .triangle  (triangle),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triangle_unit_normal regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Floor square root, one result bit per pass.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = v;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic int bit_length(input longint unsigned v);
        int n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v >>= 1;
        end
        return n;
    endfunction

    // Unit face normal of one triangle. Cross terms stay below 2^50,
    // so plain 64-bit signed arithmetic is exact here.
    function automatic tun_out_t face_normal(input tun_in_t t, input logic [31:0] thr);
        tun_out_t        r;
        longint          va[3];
        longint          vb[3];
        longint          vc[3];
        longint          e1[3];
        longint          e2[3];
        longint          n[3];
        longint unsigned mag[3];
        longint unsigned s[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned qv;
        logic [129:0]    sq_sum;
        logic [129:0]    thr_sq;
        int              bl;
        va[0] = t.a_x; va[1] = t.a_y; va[2] = t.a_z;
        vb[0] = t.b_x; vb[1] = t.b_y; vb[2] = t.b_z;
        vc[0] = t.c_x; vc[1] = t.c_y; vc[2] = t.c_z;
        if (t.swap_winding)
        begin
            vb[0] = t.c_x; vb[1] = t.c_y; vb[2] = t.c_z;
            vc[0] = t.b_x; vc[1] = t.b_y; vc[2] = t.b_z;
        end
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = vb[i] - va[i];
            e2[i] = vc[i] - va[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        sq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (n[i] < 0) ? -n[i] : n[i];
            if (mag[i] > m)
                m = mag[i];
            sq_sum += 130'(mag[i]) * 130'(mag[i]);
        end
        thr_sq = 130'(thr) * 130'(thr);
        // exact test: |n|^2 <= thr^2
        if (sq_sum <= thr_sq)
        begin
            r.normal_x   = '0;
            r.normal_y   = norm_t'(1 << FRAC);
            r.normal_z   = '0;
            r.degenerate = 1'b1;
            return r;
        end
        // bring the largest magnitude into [2^29, 2^30)
        bl  = bit_length(m);
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = (bl > 30) ? (mag[i] >> (bl - 30)) : (mag[i] << (30 - bl));
            sum += s[i] * s[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            qv = ((s[i] << (FRAC + 1)) + len) / (2 * len);
            if (n[i] < 0)
                qv = -qv;
            if (i == 0) r.normal_x = qv[15:0];
            if (i == 1) r.normal_y = qv[15:0];
            if (i == 2) r.normal_z = qv[15:0];
        end
        r.degenerate = 1'b0;
        return r;
    endfunction

    // Result checker: every done strobe must match the oldest pending normal.
    always @(posedge clk)
    begin
        tun_out_t want;
        if (rst_n && done)
        begin
            if (pending_normals.size() == 0)
                report_mismatch($sformatf("unexpected result %p", result));
            else
            begin
                want = pending_normals.pop_front();
                if (result.normal_x !== want.normal_x)
                    report_mismatch($sformatf("normal_x got %0d want %0d",
                                    result.normal_x, want.normal_x));
                if (result.normal_y !== want.normal_y)
                    report_mismatch($sformatf("normal_y got %0d want %0d",
                                    result.normal_y, want.normal_y));
                if (result.normal_z !== want.normal_z)
                    report_mismatch($sformatf("normal_z got %0d want %0d",
                                    result.normal_z, want.normal_z));
                if (result.degenerate !== want.degenerate)
                    report_mismatch($sformatf("degenerate got %0b want %0b",
                                    result.degenerate, want.degenerate));
                normal_count++;
                if (want.degenerate)
                    degen_count++;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        if (steady_stream)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(3, 30);
    endfunction

    // One command transaction: hold start until taken, then idle a while.
    // start stays high across back-to-back transactions.
    task automatic send_triangle(input tun_in_t t);
        int gap;
        start    <= 1'b1;
        triangle <= t;
        do
            @(posedge clk);
        while (busy);
        pending_normals.insert(pending_normals.size(), face_normal(t, min_len_q));
        sent_count++;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Threshold write; drains the pipe first.
    task automatic write_min_length(input logic [31:0] v);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_len_q = v;
        @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        logic [31:0] r;
        r = $urandom;
        return r[COORD_WIDTH-1:0];
    endfunction

    function automatic tun_in_t rand_triangle();
        tun_in_t t;
        t = '0;
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        t.swap_winding = $urandom_range(0, 1);
        return t;
    endfunction

    // Small triangle around a random anchor: cross product near the threshold.
    function automatic tun_in_t tiny_triangle();
        tun_in_t t;
        t = rand_triangle();
        t.b_x = coord_t'(t.a_x + coord_t'($urandom_range(0, 15)) - 8);
        t.b_y = coord_t'(t.a_y + coord_t'($urandom_range(0, 15)) - 8);
        t.b_z = coord_t'(t.a_z + coord_t'($urandom_range(0, 15)) - 8);
        t.c_x = coord_t'(t.a_x + coord_t'($urandom_range(0, 15)) - 8);
        t.c_y = coord_t'(t.a_y + coord_t'($urandom_range(0, 15)) - 8);
        t.c_z = coord_t'(t.a_z + coord_t'($urandom_range(0, 15)) - 8);
        return t;
    endfunction

    function automatic tun_in_t make_tri(input coord_t ax, ay, az, bx, by, bz,
                                         cx, cy, cz, input logic sw);
        tun_in_t t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        t.swap_winding = sw;
        return t;
    endfunction

    // Corner cases at the reset threshold.
    task automatic test_directed();
        coord_t mx;
        coord_t mn;
        mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        steady_stream = 1'b0;
        // all three vertices equal: zero cross product
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1));
        send_triangle(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0));
        // unit right triangle in the xy plane, both windings
        send_triangle(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0));
        send_triangle(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 1));
        // axis-aligned in the other planes
        send_triangle(make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0, 1));
        // collinear points
        send_triangle(make_tri(0, 0, 0, 100, 200, 300, 200, 400, 600, 0));
        // extreme edges: largest cross product
        send_triangle(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0));
        send_triangle(make_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx, 1));
        send_triangle(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn, 0));
        send_triangle(make_tri(mx, mx, mx, mn, mn, mx, mx, mn, mn, 1));
        // cross product at, just above and below the reset threshold (17)
        send_triangle(make_tri(0, 0, 0, 17, 0, 0, 0, 1, 0, 0));
        send_triangle(make_tri(0, 0, 0, 18, 0, 0, 0, 1, 0, 0));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));
        // two components set, normal off every axis
        send_triangle(make_tri(0, 0, 0, 10, 0, 10, 0, 10, 0, 0));
        // diagonal normal: components equal, rounding exercised
        send_triangle(make_tri(4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(make_tri(4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 1));
        drain_pipe();
    endtask

    // Exact threshold edge: cross product length k*j with a programmed limit.
    task automatic test_threshold();
        write_min_length(32'd0);
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
        write_min_length(32'd600);
        // 20*30 = 600: degenerate; 601 not
        send_triangle(make_tri(0, 0, 0, 20, 0, 0, 0, 30, 0, 0));
        send_triangle(make_tri(0, 0, 0, 601, 0, 0, 0, 1, 0, 1));
        // cross (360, 480, 0): 360^2 + 480^2 = 600^2 exactly
        send_triangle(make_tri(0, 0, 0, 0, 0, 1, 480, -360, 0, 0));
        write_min_length(32'hFFFF_FFFF);
        send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65535, 0, 0));
        send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65537, 0, 0));
        send_triangle(rand_triangle());
        drain_pipe();
    endtask

    // Random triangles under a given threshold; tiny ones sit near the limit.
    task automatic test_random(input logic [31:0] thr, input int count, input bit steady);
        write_min_length(thr);
        steady_stream = steady;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_triangle(tiny_triangle());
            else
                send_triangle(rand_triangle());
            // sender holds off until the pipe has emptied, once per phase
            if (i == count / 2)
                drain_pipe();
        end
        steady_stream = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        triangle      = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        min_len_q     = MIN_LENGTH_RST;
        err_count     = 0;
        cycle_count   = 0;
        sent_count    = 0;
        normal_count  = 0;
        degen_count   = 0;
        steady_stream = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold();
        test_random(32'd17, 150, 1'b0);
        test_random(32'd0, 100, 1'b1);
        test_random(32'd60, 120, 1'b0);
        test_random(32'hFFFF_FFFF, 80, 1'b0);
        test_random($urandom, 120, 1'b0);
        test_random(32'd17, 30, 1'b1);

        drain_pipe();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (pending_normals.size() != 0)
            report_mismatch($sformatf("%0d normals never arrived", pending_normals.size()));

        $display("covered %0d triangles, %0d normals checked, %0d degenerate",
                 sent_count, normal_count, degen_count);
        $display("thresholds 0, 17, 60, 600, max and random; both windings; extreme coords");
        if (err_count == 0)
            $display("triangle_unit_normal regression: pass");
        else
            $display("triangle_unit_normal regression: fail");
        $finish;
    end

endmodule

// File: triangle_unit_normal.f
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_back.sv
rtl/core/triangle_unit_normal.sv
dv/tb_triangle_unit_normal.sv
